>>> sv/affine_matrix_trs_decompose_defines.svh
// Assertion helpers for the TRS decomposition block.
`ifndef AFFINE_MATRIX_TRS_DECOMPOSE_DEFINES_SVH
`define AFFINE_MATRIX_TRS_DECOMPOSE_DEFINES_SVH

// Consequent checked in the same cycle.
`define AMTD_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");

// Consequent checked in the next cycle.
`define AMTD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`endif

>>> sv/amtd_pkg.sv
package amtd_pkg;

   localparam int SQ_STEPS  = 33;
   localparam int DIV_STEPS = 31;
   localparam int RAD_W     = 66;

   localparam logic [33:0] Q30_ONE   = 34'h0_4000_0000;
   localparam logic [31:0] Q30_ONE32 = 32'h4000_0000;

   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_X     = 2'd1;
   localparam logic [1:0] BR_Y     = 2'd2;
   localparam logic [1:0] BR_Z     = 2'd3;

   typedef struct packed {
      logic [2:0][31:0] trans;
      logic [8:0][31:0] mag;
      logic [8:0]       neg;
   } col_data_type;

   typedef struct packed {
      logic [2:0][31:0] trans;
      logic [2:0][31:0] scale;
      logic [1:0]       branch;
      logic [2:0][31:0] dmag;
      logic [2:0]       dneg;
   } br_data_type;

   typedef struct packed {
      logic [35:0] rem;
      logic [33:0] root;
   } sq_acc_type;

   typedef struct packed {
      logic [33:0] rem;
      logic [30:0] quo;
   } div_acc_type;

   // one digit of a restoring square root
   function automatic sq_acc_type sqrt_step(sq_acc_type acc, logic [1:0] bits);
      logic [35:0] r2;
      logic [35:0] trial;
      sq_acc_type  res;
      r2    = {acc.rem[33:0], bits};
      trial = {acc.root, 2'b01};
      if (r2 >= trial) begin
         res.rem  = r2 - trial;
         res.root = {acc.root[32:0], 1'b1};
      end else begin
         res.rem  = r2;
         res.root = {acc.root[32:0], 1'b0};
      end
      return res;
   endfunction

   // one quotient bit of a restoring divide
   function automatic div_acc_type div_step(div_acc_type acc, logic nbit, logic [32:0] den);
      logic [33:0] r2;
      div_acc_type res;
      r2 = {acc.rem[32:0], nbit};
      if (r2 >= {1'b0, den}) begin
         res.rem = r2 - {1'b0, den};
         res.quo = {acc.quo[29:0], 1'b1};
      end else begin
         res.rem = r2;
         res.quo = {acc.quo[29:0], 1'b0};
      end
      return res;
   endfunction

endpackage

>>> sv/affine_matrix_trs_decompose.sv
// Splits an affine matrix into translation, per-column scale and a rotation quaternion
// (Q2.30, trace or largest-diagonal branch). One transaction is taken per cycle while req_stall is
// low, and its result is registered at the output; the pipe is built from two rounds of
// bit-per-stage square root (33 stages) and restoring divide (31 stages). The whole pipe
// holds only while the output register is full and stalled.
`include "affine_matrix_trs_decompose_defines.svh"

module affine_matrix_trs_decompose #(
   parameter int IN_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_col0_x,
   input  logic [31:0] req_col0_y,
   input  logic [31:0] req_col0_z,
   input  logic [31:0] req_col1_x,
   input  logic [31:0] req_col1_y,
   input  logic [31:0] req_col1_z,
   input  logic [31:0] req_col2_x,
   input  logic [31:0] req_col2_y,
   input  logic [31:0] req_col2_z,
   input  logic [31:0] req_in_trans_x,
   input  logic [31:0] req_in_trans_y,
   input  logic [31:0] req_in_trans_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_trans_x,
   output logic [31:0] rsp_out_trans_y,
   output logic [31:0] rsp_out_trans_z,
   output logic [31:0] rsp_scale_x,
   output logic [31:0] rsp_scale_y,
   output logic [31:0] rsp_scale_z,
   output logic [31:0] rsp_quat_x,
   output logic [31:0] rsp_quat_y,
   output logic [31:0] rsp_quat_z,
   output logic [31:0] rsp_quat_w,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_min_scale
);
   import amtd_pkg::*;

   localparam int          TO_Q30      = 30 - IN_FRAC_BITS;
   localparam logic [31:0] CLAMP_LIMIT = 32'(64'd1 << IN_FRAC_BITS);

   logic        adv;
   logic [15:0] min_scale_ff;

   logic             s0_v_ff;
   logic [11:0][31:0] s0_f_ff;
   logic             s1_v_ff;
   col_data_type     s1_d_ff;
   col_data_type     s1_d_in;
   logic             s2_v_ff;
   col_data_type     s2_d_ff;
   logic [8:0][63:0] s2_sq_ff;
   logic [8:0][63:0] s2_sq_in;

   logic                      csq_v_ff   [SQ_STEPS+1];
   col_data_type              csq_d_ff   [SQ_STEPS+1];
   logic [2:0][RAD_W-1:0]     csq_rad_ff [SQ_STEPS+1];
   sq_acc_type [2:0]          csq_acc_ff [SQ_STEPS+1];
   sq_acc_type [2:0]          csq_acc_in [SQ_STEPS+1];
   logic [2:0][RAD_W-1:0]     csq_rad_in;

   logic                      dv_v_ff    [DIV_STEPS+1];
   col_data_type              dv_d_ff    [DIV_STEPS+1];
   logic [2:0][32:0]          dv_root_ff [DIV_STEPS+1];
   div_acc_type [8:0]         dv_acc_ff  [DIV_STEPS+1];
   div_acc_type [8:0]         dv_acc_in  [DIV_STEPS+1];

   logic             cc_v_ff;
   logic [2:0][31:0] cc_trans_ff;
   logic [2:0][31:0] cc_scale_ff;
   logic [8:0][31:0] cc_c_ff;
   logic [2:0][31:0] cc_scale_in;
   logic [8:0][31:0] cc_c_in;

   logic              bsq_v_ff   [SQ_STEPS+1];
   br_data_type       bsq_d_ff   [SQ_STEPS+1];
   logic [RAD_W-1:0]  bsq_rad_ff [SQ_STEPS+1];
   sq_acc_type        bsq_acc_ff [SQ_STEPS+1];
   sq_acc_type        bsq_acc_in [SQ_STEPS+1];
   br_data_type       bsq_d_in;
   logic [RAD_W-1:0]  bsq_rad_in;

   logic              fd_v_ff   [DIV_STEPS+1];
   br_data_type       fd_d_ff   [DIV_STEPS+1];
   logic [31:0]       fd_r_ff   [DIV_STEPS+1];
   logic [2:0]        fd_ovf_ff [DIV_STEPS+1];
   div_acc_type [2:0] fd_acc_ff [DIV_STEPS+1];
   div_acc_type [2:0] fd_acc_in [DIV_STEPS+1];
   logic [2:0]        fd_ovf_in;

   logic             rsp_v_ff;
   logic [2:0][31:0] rsp_trans_ff;
   logic [2:0][31:0] rsp_scale_ff;
   logic [3:0][31:0] rsp_quat_ff;
   logic [3:0][31:0] rsp_quat_in;

   assign adv       = !rsp_v_ff || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_scale_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         min_scale_ff <= csr_min_scale;
      end
   end

   // input register, magnitudes, squares
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         s1_d_in.neg[i] = s0_f_ff[i][31];
         s1_d_in.mag[i] = s0_f_ff[i][31] ? (32'd0 - s0_f_ff[i]) : s0_f_ff[i];
         s2_sq_in[i]    = 64'(s1_d_ff.mag[i]) * 64'(s1_d_ff.mag[i]);
      end
      for (int t = 0; t < 3; t++) begin
         s1_d_in.trans[t] = s0_f_ff[9+t];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff <= req_valid;
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
      end
      if (adv) begin
         s0_f_ff  <= {req_in_trans_z, req_in_trans_y, req_in_trans_x,
                      req_col2_z, req_col2_y, req_col2_x,
                      req_col1_z, req_col1_y, req_col1_x,
                      req_col0_z, req_col0_y, req_col0_x};
         s1_d_ff  <= s1_d_in;
         s2_d_ff  <= s1_d_ff;
         s2_sq_ff <= s2_sq_in;
      end
   end

   // column length: sum of squares, then one root bit per stage
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         csq_rad_in[c]    = RAD_W'(s2_sq_ff[3*c]) + RAD_W'(s2_sq_ff[3*c+1])
                            + RAD_W'(s2_sq_ff[3*c+2]);
         csq_acc_in[0][c] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         csq_v_ff[0] <= s2_v_ff;
      end
      if (adv) begin
         csq_d_ff[0]   <= s2_d_ff;
         csq_rad_ff[0] <= csq_rad_in;
         csq_acc_ff[0] <= csq_acc_in[0];
      end
   end

   for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_csq
      for (genvar c = 0; c < 3; c++) begin : g_col
         assign csq_acc_in[j][c] = sqrt_step(csq_acc_ff[j-1][c],
                                             csq_rad_ff[j-1][c][RAD_W+1-2*j -: 2]);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            csq_v_ff[j] <= 1'b0;
         end else if (adv) begin
            csq_v_ff[j] <= csq_v_ff[j-1];
         end
         if (adv) begin
            csq_d_ff[j]   <= csq_d_ff[j-1];
            csq_rad_ff[j] <= csq_rad_ff[j-1];
            csq_acc_ff[j] <= csq_acc_in[j];
         end
      end
   end

   // normalising divides, one quotient bit per stage
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         dv_acc_in[0][i].rem = 34'(csq_d_ff[SQ_STEPS].mag[i] >> 1);
         dv_acc_in[0][i].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= csq_v_ff[SQ_STEPS];
      end
      if (adv) begin
         dv_d_ff[0] <= csq_d_ff[SQ_STEPS];
         for (int c = 0; c < 3; c++) begin
            dv_root_ff[0][c] <= csq_acc_ff[SQ_STEPS][c].root[32:0];
         end
         dv_acc_ff[0] <= dv_acc_in[0];
      end
   end

   for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_dv
      for (genvar i = 0; i < 9; i++) begin : g_elem
         assign dv_acc_in[j][i] = div_step(dv_acc_ff[j-1][i],
                                           (j == 1) ? dv_d_ff[j-1].mag[i][0] : 1'b0,
                                           dv_root_ff[j-1][i/3]);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[j] <= dv_v_ff[j-1];
         end
         if (adv) begin
            dv_d_ff[j]    <= dv_d_ff[j-1];
            dv_root_ff[j] <= dv_root_ff[j-1];
            dv_acc_ff[j]  <= dv_acc_in[j];
         end
      end
   end

   // basis entries in Q2.30 and saturated scale
   always_comb begin
      logic [31:0] mag;
      logic [31:0] val;
      logic        norm;
      for (int i = 0; i < 9; i++) begin
         mag  = dv_d_ff[DIV_STEPS].mag[i];
         norm = dv_root_ff[DIV_STEPS][i/3] > 33'(min_scale_ff);
         if (norm) begin
            val = {1'b0, dv_acc_ff[DIV_STEPS][i].quo};
         end else if (mag > CLAMP_LIMIT) begin
            val = Q30_ONE32;
         end else begin
            val = mag << TO_Q30;
         end
         cc_c_in[i] = dv_d_ff[DIV_STEPS].neg[i] ? (32'd0 - val) : val;
      end
      for (int c = 0; c < 3; c++) begin
         cc_scale_in[c] = dv_root_ff[DIV_STEPS][c][32] ? '1
                                                       : dv_root_ff[DIV_STEPS][c][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_v_ff <= 1'b0;
      end else if (adv) begin
         cc_v_ff <= dv_v_ff[DIV_STEPS];
      end
      if (adv) begin
         cc_trans_ff <= dv_d_ff[DIV_STEPS].trans;
         cc_scale_ff <= cc_scale_in;
         cc_c_ff     <= cc_c_in;
      end
   end

   // branch choice, radicand and numerators
   always_comb begin
      logic signed [33:0] ce [9];
      logic signed [33:0] trace;
      logic signed [33:0] rad;
      logic signed [33:0] d [3];
      for (int i = 0; i < 9; i++) begin
         ce[i] = 34'($signed(cc_c_ff[i]));
      end
      trace = ce[0] + ce[4] + ce[8];
      bsq_d_in.trans = cc_trans_ff;
      bsq_d_in.scale = cc_scale_ff;
      priority if (trace > 0) begin
         bsq_d_in.branch = BR_TRACE;
         rad  = trace + $signed(Q30_ONE);
         d[0] = ce[5] - ce[7];
         d[1] = ce[6] - ce[2];
         d[2] = ce[1] - ce[3];
      end else if (ce[0] > ce[4] && ce[0] > ce[8]) begin
         bsq_d_in.branch = BR_X;
         rad  = $signed(Q30_ONE) + ce[0] - ce[4] - ce[8];
         d[0] = ce[5] - ce[7];
         d[1] = ce[3] + ce[1];
         d[2] = ce[6] + ce[2];
      end else if (ce[4] > ce[8]) begin
         bsq_d_in.branch = BR_Y;
         rad  = $signed(Q30_ONE) + ce[4] - ce[0] - ce[8];
         d[0] = ce[6] - ce[2];
         d[1] = ce[3] + ce[1];
         d[2] = ce[7] + ce[5];
      end else begin
         bsq_d_in.branch = BR_Z;
         rad  = $signed(Q30_ONE) + ce[8] - ce[0] - ce[4];
         d[0] = ce[1] - ce[3];
         d[1] = ce[6] + ce[2];
         d[2] = ce[7] + ce[5];
      end
      for (int t = 0; t < 3; t++) begin
         bsq_d_in.dneg[t] = d[t][33];
         bsq_d_in.dmag[t] = d[t][33] ? 32'(34'd0 - d[t]) : d[t][31:0];
      end
      bsq_rad_in    = (rad > 0) ? {3'b000, rad[32:0], 30'd0} : '0;
      bsq_acc_in[0] = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         bsq_v_ff[0] <= cc_v_ff;
      end
      if (adv) begin
         bsq_d_ff[0]   <= bsq_d_in;
         bsq_rad_ff[0] <= bsq_rad_in;
         bsq_acc_ff[0] <= bsq_acc_in[0];
      end
   end

   for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_bsq
      assign bsq_acc_in[j] = sqrt_step(bsq_acc_ff[j-1], bsq_rad_ff[j-1][RAD_W+1-2*j -: 2]);
      always_ff @(posedge clock) begin
         if (reset) begin
            bsq_v_ff[j] <= 1'b0;
         end else if (adv) begin
            bsq_v_ff[j] <= bsq_v_ff[j-1];
         end
         if (adv) begin
            bsq_d_ff[j]   <= bsq_d_ff[j-1];
            bsq_rad_ff[j] <= bsq_rad_ff[j-1];
            bsq_acc_ff[j] <= bsq_acc_in[j];
         end
      end
   end

   // quaternion divides by k = 2r
   always_comb begin
      logic [31:0] r;
      r = bsq_acc_ff[SQ_STEPS].root[31:0];
      for (int t = 0; t < 3; t++) begin
         fd_ovf_in[t]        = {2'b00, bsq_d_ff[SQ_STEPS].dmag[t]} >= {r, 2'b00};
         fd_acc_in[0][t].rem = 34'(bsq_d_ff[SQ_STEPS].dmag[t] >> 1);
         fd_acc_in[0][t].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fd_v_ff[0] <= 1'b0;
      end else if (adv) begin
         fd_v_ff[0] <= bsq_v_ff[SQ_STEPS];
      end
      if (adv) begin
         fd_d_ff[0]   <= bsq_d_ff[SQ_STEPS];
         fd_r_ff[0]   <= bsq_acc_ff[SQ_STEPS].root[31:0];
         fd_ovf_ff[0] <= fd_ovf_in;
         fd_acc_ff[0] <= fd_acc_in[0];
      end
   end

   for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_fd
      for (genvar t = 0; t < 3; t++) begin : g_num
         assign fd_acc_in[j][t] = div_step(fd_acc_ff[j-1][t],
                                           (j == 1) ? fd_d_ff[j-1].dmag[t][0] : 1'b0,
                                           {fd_r_ff[j-1], 1'b0});
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            fd_v_ff[j] <= 1'b0;
         end else if (adv) begin
            fd_v_ff[j] <= fd_v_ff[j-1];
         end
         if (adv) begin
            fd_d_ff[j]   <= fd_d_ff[j-1];
            fd_r_ff[j]   <= fd_r_ff[j-1];
            fd_ovf_ff[j] <= fd_ovf_ff[j-1];
            fd_acc_ff[j] <= fd_acc_in[j];
         end
      end
   end

   // saturate and place components
   always_comb begin
      logic [31:0] comp [3];
      logic [31:0] main_c;
      logic [31:0] q;
      for (int t = 0; t < 3; t++) begin
         q = {1'b0, fd_acc_ff[DIV_STEPS][t].quo};
         priority if (fd_r_ff[DIV_STEPS] == '0) begin
            comp[t] = '0;
         end else if (fd_ovf_ff[DIV_STEPS][t]) begin
            comp[t] = fd_d_ff[DIV_STEPS].dneg[t] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            comp[t] = fd_d_ff[DIV_STEPS].dneg[t] ? (32'd0 - q) : q;
         end
      end
      main_c = {1'b0, fd_r_ff[DIV_STEPS][31:1]};
      // order: x, y, z, w
      unique case (fd_d_ff[DIV_STEPS].branch)
         BR_TRACE: rsp_quat_in = {main_c, comp[2], comp[1], comp[0]};
         BR_X:     rsp_quat_in = {comp[0], comp[2], comp[1], main_c};
         BR_Y:     rsp_quat_in = {comp[0], comp[2], main_c, comp[1]};
         default:  rsp_quat_in = {comp[0], main_c, comp[2], comp[1]};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= fd_v_ff[DIV_STEPS];
      end
      if (adv) begin
         rsp_trans_ff <= fd_d_ff[DIV_STEPS].trans;
         rsp_scale_ff <= fd_d_ff[DIV_STEPS].scale;
         rsp_quat_ff  <= rsp_quat_in;
      end
   end

   assign rsp_valid       = rsp_v_ff;
   assign rsp_out_trans_x = rsp_trans_ff[0];
   assign rsp_out_trans_y = rsp_trans_ff[1];
   assign rsp_out_trans_z = rsp_trans_ff[2];
   assign rsp_scale_x     = rsp_scale_ff[0];
   assign rsp_scale_y     = rsp_scale_ff[1];
   assign rsp_scale_z     = rsp_scale_ff[2];
   assign rsp_quat_x      = rsp_quat_ff[0];
   assign rsp_quat_y      = rsp_quat_ff[1];
   assign rsp_quat_z      = rsp_quat_ff[2];
   assign rsp_quat_w      = rsp_quat_ff[3];

   `AMTD_ASSERT_SAME(a_full_stall, clock, reset, rsp_v_ff && rsp_stall, req_stall)
   `AMTD_ASSERT_NEXT(a_drain, clock, reset, fd_v_ff[DIV_STEPS] && !req_stall, rsp_v_ff)
   `AMTD_ASSERT_NEXT(a_csr_write, clock, reset, csr_valid && csr_ready, min_scale_ff == $past(csr_min_scale))

endmodule

>>> tb/affine_matrix_trs_decompose_tb.sv
module affine_matrix_trs_decompose_tb;

   typedef struct packed {
      logic [31:0] tx, ty, tz;
      logic [31:0] sx, sy, sz;
      logic [31:0] qx, qy, qz, qw;
   } trs_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_col [0:8] = '{default: '0};
   logic [31:0] req_in_trans_x = '0, req_in_trans_y = '0, req_in_trans_z = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_out_trans_x, rsp_out_trans_y, rsp_out_trans_z;
   logic [31:0] rsp_scale_x, rsp_scale_y, rsp_scale_z;
   logic [31:0] rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_min_scale = '0;

   logic [15:0] min_scale_q = '0;
   trs_type     expected_trs [$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   affine_matrix_trs_decompose uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_col0_x(req_col[0]), .req_col0_y(req_col[1]), .req_col0_z(req_col[2]),
      .req_col1_x(req_col[3]), .req_col1_y(req_col[4]), .req_col1_z(req_col[5]),
      .req_col2_x(req_col[6]), .req_col2_y(req_col[7]), .req_col2_z(req_col[8]),
      .req_in_trans_x(req_in_trans_x), .req_in_trans_y(req_in_trans_y),
      .req_in_trans_z(req_in_trans_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_trans_x(rsp_out_trans_x), .rsp_out_trans_y(rsp_out_trans_y),
      .rsp_out_trans_z(rsp_out_trans_z),
      .rsp_scale_x(rsp_scale_x), .rsp_scale_y(rsp_scale_y), .rsp_scale_z(rsp_scale_z),
      .rsp_quat_x(rsp_quat_x), .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z),
      .rsp_quat_w(rsp_quat_w),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_min_scale(csr_min_scale)
   );

   initial forever #1 clock = ~clock;

   // floor square root, bit by bit
   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] abs64(logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   // (num << 30) / den toward zero, capped at 2^40
   function automatic logic signed [63:0] q30_quot(logic signed [63:0] num, logic [63:0] den);
      logic [63:0] q;
      if (den == 0) return 0;
      q = (abs64(num) << 30) / den;
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      return num < 0 ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic [31:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic logic [63:0] column_basis(logic [31:0] a, b, c,
                                                output logic signed [63:0] u [0:2]);
      logic signed [63:0] v [0:2];
      logic [63:0] sum, root, m;
      v[0] = $signed(a); v[1] = $signed(b); v[2] = $signed(c);
      sum = 0;
      for (int i = 0; i < 3; i++) sum += abs64(v[i]) * abs64(v[i]);
      root = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         if (root > min_scale_q) begin
            u[i] = q30_quot(v[i], root);
         end else begin
            m = abs64(v[i]) << 14;
            if (m > (64'd1 << 30)) m = 64'd1 << 30;
            u[i] = v[i] < 0 ? -$signed(m) : $signed(m);
         end
      end
      return root;
   endfunction

   function automatic logic [63:0] branch_sqrt(logic signed [63:0] a);
      if (a <= 0) return 0;
      return int_sqrt(a << 30);
   endfunction

   function automatic trs_type decompose(logic [31:0] c [0:8], logic [31:0] t [0:2]);
      logic signed [63:0] m0 [0:2], m1 [0:2], m2 [0:2];
      logic signed [63:0] one, tr, x, y, z, w;
      logic [63:0] s [0:2], r, k;
      trs_type o;
      one = 64'sd1 << 30;
      s[0] = column_basis(c[0], c[1], c[2], m0);
      s[1] = column_basis(c[3], c[4], c[5], m1);
      s[2] = column_basis(c[6], c[7], c[8], m2);
      tr = m0[0] + m1[1] + m2[2];
      if (tr > 0) begin
         r = branch_sqrt(tr + one); k = r << 1;
         w = r >> 1;
         x = q30_quot(m1[2] - m2[1], k);
         y = q30_quot(m2[0] - m0[2], k);
         z = q30_quot(m0[1] - m1[0], k);
      end else if (m0[0] > m1[1] && m0[0] > m2[2]) begin
         r = branch_sqrt(one + m0[0] - m1[1] - m2[2]); k = r << 1;
         w = q30_quot(m1[2] - m2[1], k);
         x = r >> 1;
         y = q30_quot(m1[0] + m0[1], k);
         z = q30_quot(m2[0] + m0[2], k);
      end else if (m1[1] > m2[2]) begin
         r = branch_sqrt(one + m1[1] - m0[0] - m2[2]); k = r << 1;
         w = q30_quot(m2[0] - m0[2], k);
         x = q30_quot(m1[0] + m0[1], k);
         y = r >> 1;
         z = q30_quot(m2[1] + m1[2], k);
      end else begin
         r = branch_sqrt(one + m2[2] - m0[0] - m1[1]); k = r << 1;
         w = q30_quot(m0[1] - m1[0], k);
         x = q30_quot(m2[0] + m0[2], k);
         y = q30_quot(m2[1] + m1[2], k);
         z = r >> 1;
      end
      o.tx = t[0]; o.ty = t[1]; o.tz = t[2];
      o.sx = s[0] > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[0][31:0];
      o.sy = s[1] > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[1][31:0];
      o.sz = s[2] > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[2][31:0];
      o.qx = clamp32(x); o.qy = clamp32(y); o.qz = clamp32(z); o.qw = clamp32(w);
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      trs_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_trs.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_quat_w, '0);
            end else begin
               e = expected_trs.pop_front();
               if (rsp_out_trans_x !== e.tx) report_mismatch("out_trans_x", rsp_out_trans_x, e.tx);
               if (rsp_out_trans_y !== e.ty) report_mismatch("out_trans_y", rsp_out_trans_y, e.ty);
               if (rsp_out_trans_z !== e.tz) report_mismatch("out_trans_z", rsp_out_trans_z, e.tz);
               if (rsp_scale_x !== e.sx) report_mismatch("scale_x", rsp_scale_x, e.sx);
               if (rsp_scale_y !== e.sy) report_mismatch("scale_y", rsp_scale_y, e.sy);
               if (rsp_scale_z !== e.sz) report_mismatch("scale_z", rsp_scale_z, e.sz);
               if (rsp_quat_x !== e.qx) report_mismatch("quat_x", rsp_quat_x, e.qx);
               if (rsp_quat_y !== e.qy) report_mismatch("quat_y", rsp_quat_y, e.qy);
               if (rsp_quat_z !== e.qz) report_mismatch("quat_z", rsp_quat_z, e.qz);
               if (rsp_quat_w !== e.qw) report_mismatch("quat_w", rsp_quat_w, e.qw);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("watchdog expired");
         $display("** affine_matrix_trs_decompose: FAILED **");
         $finish;
      end
   end

   task automatic send_matrix(logic [31:0] c [0:8], logic [31:0] t [0:2]);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      for (int i = 0; i < 9; i++) req_col[i] <= c[i];
      req_in_trans_x <= t[0]; req_in_trans_y <= t[1]; req_in_trans_z <= t[2];
      expected_trs.insert(expected_trs.size(), decompose(c, t));
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_trs.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_min_scale(logic [15:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_min_scale <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      min_scale_q = v;
   endtask

   function automatic logic [31:0] any_word();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'h8000_0000 | $urandom_range(3);
         2: return 32'h7FFF_FFFF - $urandom_range(3);
         3: return $urandom_range(4) - 2;
         default: return $signed($urandom_range(262143)) - 131072;
      endcase
   endfunction

   // near-rotation with random scale, sign flips and noise
   task automatic send_rotation_like();
      logic [31:0] c [0:8], t [0:2];
      int sc;
      int perm;
      sc = $urandom_range(3) == 0 ? $urandom_range(20) : 32'h10000 >> $urandom_range(8);
      for (int i = 0; i < 9; i++) c[i] = $signed($urandom_range(8191)) - 4096;
      perm = $urandom_range(5);
      for (int j = 0; j < 3; j++)
         c[3*j + (j + perm) % 3] += ($urandom_range(1) ? sc : -sc);
      if ($urandom_range(9) == 0) c[$urandom_range(8)] = any_word();
      for (int i = 0; i < 3; i++) t[i] = any_word();
      send_matrix(c, t);
   endtask

   task automatic send_noise();
      logic [31:0] c [0:8], t [0:2];
      for (int i = 0; i < 9; i++) c[i] = any_word();
      for (int i = 0; i < 3; i++) t[i] = any_word();
      send_matrix(c, t);
   endtask

   task automatic test_directed();
      logic [31:0] c [0:8], t [0:2];
      logic [31:0] ext [0:5];
      ext = '{32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1};
      t = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
      for (int n = 0; n < 6; n++) begin
         for (int i = 0; i < 9; i++) c[i] = ext[(n + i) % 6];
         send_matrix(c, t);
      end
      c = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
      send_matrix(c, t);                       // identity, trace branch
      c = '{32'h10000, 0, 0, 0, 32'hFFFF0000, 0, 0, 0, 32'hFFFF0000};
      send_matrix(c, t);                       // x branch
      c = '{32'hFFFF0000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'hFFFF0000};
      send_matrix(c, t);                       // y branch
      c = '{32'hFFFF0000, 0, 0, 0, 32'hFFFF0000, 0, 0, 0, 32'h10000};
      send_matrix(c, t);                       // z branch
      c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      send_matrix(c, t);                       // zero matrix, z branch, zero numerators
      c = '{32'hFFFF0000, 0, 0, 0, 32'hFFFF0000, 0, 0, 0, 32'hFFFF0000};
      send_matrix(c, t);                       // tie, falls to the z branch
      for (int i = 0; i < 9; i++) c[i] = 32'h8000_0000;
      send_matrix(c, t);                       // most negative entries
      for (int i = 0; i < 9; i++) c[i] = 32'h7FFF_FFFF;
      send_matrix(c, t);
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(3) == 0) send_noise();
         else send_rotation_like();
         if (n == count / 2) drain();          // sender holds off until empty
      end
   endtask

   task automatic test_min_scale(logic [15:0] v, int count);
      write_min_scale(v);
      for (int n = 0; n < count; n++) send_rotation_like();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 30; recv_idle_pct = 83;
      test_directed();
      test_random(400);
      test_min_scale(16'hFFFF, 150);
      send_idle_pct = 83; recv_idle_pct = 30;
      test_directed();
      test_min_scale(16'h0100, 300);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_min_scale(16'h4000, 300);
      test_min_scale(16'h0000, 150);
      test_random(400);
      drain();
      if (mismatches == 0)
         $display("** affine_matrix_trs_decompose: PASSED **");
      else
         $display("** affine_matrix_trs_decompose: FAILED **");
      $finish;
   end

endmodule
